// ===== hdl/lshc_pkg.sv =====
// Shared constants, types and bin math for the allocation histogram block.
`timescale 1ns / 1ps
package lshc_pkg;

	// configuration of the statistics tables
	localparam int NUM_CLASSES = 4;
	localparam int NUM_BINS    = 64;
	localparam int EXACT_BITS  = 4;
	localparam int COUNT_BITS  = 48;

	// fixed field widths
	localparam int KIND_W = 2;
	localparam int CLS_W  = 2;
	localparam int AMT_W  = 48;
	localparam int IDX_W  = 6;
	localparam int SUM_W  = 64;
	localparam int LIM_W  = 48;
	localparam int TOP_W  = 6;

	// derived sizes
	localparam int CLS_DEPTH  = NUM_CLASSES + 1;
	localparam int CLS_AW     = $clog2(CLS_DEPTH);
	localparam int BIN_AW     = $clog2(NUM_BINS);
	localparam int EXACT_SPAN = 1 << EXACT_BITS;
	localparam int BIN_OFS    = EXACT_SPAN - EXACT_BITS - 1;
	localparam logic [CLS_AW-1:0] TOTAL_ADDR = CLS_AW'(NUM_CLASSES);
	localparam logic [AMT_W-1:0] AMT_MASK =
		AMT_W'((65'(1) << COUNT_BITS) - 65'(1));

	// item kinds
	localparam logic [KIND_W-1:0] KIND_REC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLS  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BIN  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	// one table entry: allocation count and three wrapping sums
	typedef struct packed {
		logic [SUM_W-1:0] cnt;
		logic [SUM_W-1:0] esum;
		logic [SUM_W-1:0] bsum;
		logic [SUM_W-1:0] asum;
	} entry_t;

	// amounts added by one record
	typedef struct packed {
		logic [AMT_W-1:0] ne;
		logic [AMT_W-1:0] nb;
		logic [AMT_W-1:0] na;
	} amt_t;

	// exact bins below EXACT_SPAN, then one bin per bit length
	function automatic logic [BIN_AW-1:0] size_bin(input logic [AMT_W-1:0] n);
		int len;
		int b;
		len = 0;
		for (int i = 0; i < AMT_W; i++) begin
			if (n[i]) len = i + 1;
		end
		if (n < AMT_W'(EXACT_SPAN)) begin
			b = int'(n[7:0]);
		end else begin
			b = len + BIN_OFS;
		end
		if (b > NUM_BINS - 1) b = NUM_BINS - 1;
		return BIN_AW'(b);
	endfunction

	// smallest (upper = 0) or largest (upper = 1) count of a bin, saturated
	function automatic logic [LIM_W-1:0] bin_lim(input logic [BIN_AW-1:0] b,
			input logic upper);
		int sh;
		logic [LIM_W:0] one;
		one = (LIM_W+1)'(1);
		sh = int'(b) - EXACT_SPAN + EXACT_BITS + (upper ? 1 : 0);
		if (int'(b) < EXACT_SPAN) return LIM_W'(b);
		if (sh >= LIM_W) return {LIM_W{1'b1}};
		if (upper) return LIM_W'((one << sh) - one);
		return LIM_W'(one << sh);
	endfunction

endpackage

// ===== hdl/lshc_req_if.sv =====
// Request channel: record and read items.
`timescale 1ns / 1ps
interface lshc_req_if;
	import lshc_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CLS_W-1:0]  vector_class;
	logic [AMT_W-1:0]  element_count;
	logic [AMT_W-1:0]  byte_size;
	logic [AMT_W-1:0]  aligned_size;
	logic [IDX_W-1:0]  read_index;

	modport source (output valid, kind, vector_class, element_count, byte_size,
		aligned_size, read_index, input ready);
	modport sink (input valid, kind, vector_class, element_count, byte_size,
		aligned_size, read_index, output ready);
endinterface

// ===== hdl/lshc_rsp_if.sv =====
// Response channel: one entry per read item.
`timescale 1ns / 1ps
interface lshc_rsp_if;
	import lshc_pkg::*;

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] alloc_total;
	logic [SUM_W-1:0] element_sum;
	logic [SUM_W-1:0] byte_sum;
	logic [SUM_W-1:0] aligned_sum;
	logic [LIM_W-1:0] bin_low_limit;
	logic [LIM_W-1:0] bin_high_limit;
	logic [TOP_W-1:0] top_bin;

	modport source (output valid, alloc_total, element_sum, byte_sum, aligned_sum,
		bin_low_limit, bin_high_limit, top_bin, input ready);
	modport sink (input valid, alloc_total, element_sum, byte_sum, aligned_sum,
		bin_low_limit, bin_high_limit, top_bin, output ready);
endinterface

// ===== hdl/lshc_ram.sv =====
// Entry store: one write and one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
module lshc_ram #(
	parameter int DEPTH = 64,
	parameter int W = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata
);
	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [W-1:0]     rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (re) rvld_q <= (int'(raddr) < DEPTH) && vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;
endmodule

// ===== hdl/lshc_upd.sv =====
// Adds one record to an entry: count plus one, sums wrap at 64 bits.
`timescale 1ns / 1ps
module lshc_upd (
	input  lshc_pkg::entry_t cur,
	input  lshc_pkg::amt_t   amt,
	output lshc_pkg::entry_t nxt
);
	import lshc_pkg::*;

	assign nxt.cnt  = cur.cnt + SUM_W'(1);
	assign nxt.esum = cur.esum + SUM_W'(amt.ne);
	assign nxt.bsum = cur.bsum + SUM_W'(amt.nb);
	assign nxt.asum = cur.asum + SUM_W'(amt.na);
endmodule

// ===== hdl/log2_size_histogram_counter_top.sv =====
// Top level: allocation statistics engine with a log2-binned size histogram.
`timescale 1ns / 1ps
// Allocation statistics engine. A record beat (kind 0) adds one allocation and
// its element count, byte size and aligned size to its class entry, the total
// entry and one size bin; it returns nothing. Counts below 16 have exact bins,
// larger counts share one bin per power of two (bin = bit length + 11), capped
// at the last bin. A read beat (kind 1 class, index 4 = total; kind 2 bin)
// returns one response beat with the entry, the bin limits for bin reads and
// the highest bin seen so far; out-of-range indices return zero sums and
// limits. Kind 3 is dropped. Items are handled one at a time: a record steps
// through accept, read of class and bin stores, write of class and bin while
// reading the total, and write of the total; a read steps through accept,
// store read and response register, waiting there while a held beat is not
// taken by rsp.ready. Both sequences come from the single write port of the
// class store and the registered read of the stores. All stores read as zero
// after reset through per-entry valid bits, so there is no clearing pass and
// the block takes items as soon as reset is released.
module log2_size_histogram_counter_top (
	input logic       clk,
	input logic       arst_n,
	lshc_req_if.sink  req,
	lshc_rsp_if.source rsp
);
	import lshc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_TOTAL = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	logic [CLS_W-1:0]  cls_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BIN_AW-1:0] bin_q;
	logic [BIN_AW-1:0] hb_q;
	amt_t              amt_q;
	logic              rng_q;

	// response register
	logic              out_vld_q;
	entry_t            out_ent_q;
	logic [LIM_W-1:0]  out_lo_q, out_hi_q;
	logic [TOP_W-1:0]  out_top_q;

	// store ports
	logic              cls_re, cls_we, bin_re, bin_we;
	logic [CLS_AW-1:0] cls_raddr, cls_waddr;
	logic [BIN_AW-1:0] bin_raddr, bin_waddr;
	entry_t            cls_rdata, bin_rdata, cls_next, bin_next;

	logic              accept, cls_ok, out_load, read_ok;
	amt_t              amt_in;

	assign accept  = req.valid && req.ready;
	assign cls_ok  = int'(cls_q) < NUM_CLASSES;
	assign read_ok = (kind_q == KIND_CLS) ? (int'(idx_q) <= NUM_CLASSES)
		: (int'(idx_q) < NUM_BINS);
	assign out_load = (state_q == ST_RESP) && (!out_vld_q || rsp.ready);

	assign amt_in.ne = req.element_count & AMT_MASK;
	assign amt_in.nb = req.byte_size & AMT_MASK;
	assign amt_in.na = req.aligned_size & AMT_MASK;

	lshc_ram #(.DEPTH(CLS_DEPTH), .W($bits(entry_t))) u_cls_ram (
		.clk, .arst_n,
		.re(cls_re), .raddr(cls_raddr), .rdata(cls_rdata),
		.we(cls_we), .waddr(cls_waddr), .wdata(cls_next)
	);

	lshc_ram #(.DEPTH(NUM_BINS), .W($bits(entry_t))) u_bin_ram (
		.clk, .arst_n,
		.re(bin_re), .raddr(bin_raddr), .rdata(bin_rdata),
		.we(bin_we), .waddr(bin_waddr), .wdata(bin_next)
	);

	lshc_upd u_cls_upd (.cur(cls_rdata), .amt(amt_q), .nxt(cls_next));
	lshc_upd u_bin_upd (.cur(bin_rdata), .amt(amt_q), .nxt(bin_next));

	// sequencer: read, modify, write back; class and bin entries then total entry, or one store read for a read item
	always_comb begin
		state_d   = state_q;
		cls_re    = 1'b0;
		cls_we    = 1'b0;
		bin_re    = 1'b0;
		bin_we    = 1'b0;
		cls_raddr = CLS_AW'(cls_q);
		cls_waddr = CLS_AW'(cls_q);
		bin_raddr = bin_q;
		bin_waddr = bin_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.kind != KIND_NONE) state_d = ST_READ;
			end
			ST_READ: begin
				priority if (kind_q == KIND_REC) begin
					cls_re  = cls_ok;
					bin_re  = 1'b1;
					state_d = ST_UPD;
				end else if (kind_q == KIND_CLS) begin
					cls_re    = read_ok;
					cls_raddr = CLS_AW'(idx_q);
					state_d   = ST_RESP;
				end else begin
					bin_re    = read_ok;
					bin_raddr = BIN_AW'(idx_q);
					state_d   = ST_RESP;
				end
			end
			ST_UPD: begin
				cls_we    = cls_ok;
				bin_we    = 1'b1;
				cls_re    = 1'b1;
				cls_raddr = TOTAL_ADDR;
				state_d   = ST_TOTAL;
			end
			ST_TOTAL: begin
				cls_we    = 1'b1;
				cls_waddr = TOTAL_ADDR;
				state_d   = ST_IDLE;
			end
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hb_q      <= '0;
			out_vld_q <= 1'b0;
			rng_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPD && bin_q > hb_q) hb_q <= bin_q;
			if (state_q == ST_READ) rng_q <= read_ok;
			if (out_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// item payload, held for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			cls_q  <= req.vector_class;
			idx_q  <= req.read_index;
			amt_q  <= amt_in;
			bin_q  <= size_bin(amt_in.ne);
		end
	end

	// response payload; zeros when the index was out of range
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_top_q <= TOP_W'(hb_q);
			if (!rng_q) begin
				out_ent_q <= '0;
				out_lo_q  <= '0;
				out_hi_q  <= '0;
			end else if (kind_q == KIND_CLS) begin
				out_ent_q <= cls_rdata;
				out_lo_q  <= '0;
				out_hi_q  <= '0;
			end else begin
				out_ent_q <= bin_rdata;
				out_lo_q  <= bin_lim(BIN_AW'(idx_q), 1'b0);
				out_hi_q  <= bin_lim(BIN_AW'(idx_q), 1'b1);
			end
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.alloc_total    = out_ent_q.cnt;
	assign rsp.element_sum    = out_ent_q.esum;
	assign rsp.byte_sum       = out_ent_q.bsum;
	assign rsp.aligned_sum    = out_ent_q.asum;
	assign rsp.bin_low_limit  = out_lo_q;
	assign rsp.bin_high_limit = out_hi_q;
	assign rsp.top_bin        = out_top_q;

	// a new response only comes out of the response state of a read item
	a_resp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_RESP)
		else $error("response without a read sequence");

	// the class store never reads and writes the same entry in one cycle
	a_cls_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_we && cls_re) |-> cls_waddr != cls_raddr)
		else $error("class store read/write collision");

	// the highest bin seen never goes down
	a_hb_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hb_q >= $past(hb_q))
		else $error("highest bin decreased");
endmodule
